// ===== rtl/rv32ie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32ie_pkg
// Shared constants and types of the RV32 integer execute unit: opcodes,
// function codes, status codes and the execute result bundle.
// ----------------------------------------------------------------------------
package rv32ie_pkg;

	localparam int REGISTER_COUNT = 32;

	localparam logic [6:0] OPC_ARITH_I = 7'b0010011;
	localparam logic [6:0] OPC_ARITH_R = 7'b0110011;
	localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
	localparam logic [6:0] OPC_JALR    = 7'b1100111;
	localparam logic [6:0] OPC_JAL     = 7'b1101111;
	localparam logic [6:0] OPC_LUI     = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
	localparam logic [6:0] OPC_ENV     = 7'b1110011;

	localparam logic [4:0] SHAMT_MASK = 5'b11111;

	localparam logic [2:0] F3_ADD  = 3'b000;
	localparam logic [2:0] F3_SLL  = 3'b001;
	localparam logic [2:0] F3_SLT  = 3'b010;
	localparam logic [2:0] F3_SLTU = 3'b011;
	localparam logic [2:0] F3_XOR  = 3'b100;
	localparam logic [2:0] F3_SRL  = 3'b101;
	localparam logic [2:0] F3_OR   = 3'b110;
	localparam logic [2:0] F3_AND  = 3'b111;

	localparam logic [2:0] F3_BEQ  = 3'b000;
	localparam logic [2:0] F3_BNE  = 3'b001;
	localparam logic [2:0] F3_BLT  = 3'b100;
	localparam logic [2:0] F3_BGE  = 3'b101;
	localparam logic [2:0] F3_BLTU = 3'b110;
	localparam logic [2:0] F3_BGEU = 3'b111;

	localparam logic [11:0] ENV_EXIT = 12'd0;
	localparam logic [11:0] ENV_HALT = 12'd1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
	localparam logic [1:0] STATUS_EXIT    = 2'd2;
	localparam logic [1:0] STATUS_HALT    = 2'd3;

	localparam logic [31:0] JUMP_STALL = 32'd2;
	localparam logic [31:0] PC_STEP    = 32'd4;

	typedef struct packed {
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic [31:0] npc;
		logic [1:0]  status;
		logic        jump;
	} exec_result_t;

endpackage
`default_nettype wire

// ===== rtl/rv32_integer_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_integer_execute_unit
// Executes one RV32 integer instruction per cycle, unless the output stalls,
// against its own register file, program counter and stall counter. A request
// enters an input stage that reads both source registers from the register
// file RAMs; the instruction then executes, writes back and lands in the
// result register, so the unit takes one instruction per cycle while the
// output is not stalled. That rate is set by the write-back to register read
// loop, closed by a bypass of the executing write into the operands of the
// request accepted at the same edge. The register file starts as all zero
// through a valid bit per entry.
// ----------------------------------------------------------------------------
module rv32_integer_execute_unit #(
	parameter int REGISTER_COUNT = rv32ie_pkg::REGISTER_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instruction,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             write_enable,
	output logic [4:0]       write_register,
	output logic [31:0]      write_value,
	output logic [31:0]      next_pc,
	output logic [1:0]       status,
	output logic [31:0]      stall_total
);

	localparam int AW = $clog2(REGISTER_COUNT);

	function automatic logic reg_ok(input logic [4:0] idx);
		return (idx != 5'd0) && ({1'b0, idx} < 6'(REGISTER_COUNT));
	endfunction

	logic                      valid_s1;
	logic [31:0]               instr_s1;
	logic                      ok1_s1;
	logic                      ok2_s1;
	logic                      fwd1_s1;
	logic                      fwd2_s1;
	logic [31:0]               fwd_val_s1;
	logic                      valid_s2;
	logic [31:0]               pc_q;
	logic [31:0]               stall_q;
	logic [REGISTER_COUNT-1:0] rf_valid_q;

	logic                      accept;
	logic                      s1_adv;
	logic [4:0]                rs1_in;
	logic [4:0]                rs2_in;
	logic                      wb;
	logic                      fwd1;
	logic                      fwd2;
	logic [31:0]               rd1_data;
	logic [31:0]               rd2_data;
	logic [31:0]               src_a;
	logic [31:0]               src_b;
	logic [31:0]               stall_next;
	rv32ie_pkg::exec_result_t  res;

	assign s1_adv   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;
	assign rs1_in   = instruction[19:15];
	assign rs2_in   = instruction[24:20];
	assign wb       = s1_adv && res.wr;
	assign fwd1     = wb && (res.rd == rs1_in);
	assign fwd2     = wb && (res.rd == rs2_in);

	rv32ie_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_rf_a (
		.clk     (clk),
		.wr_en   (wb),
		.wr_addr (res.rd[AW-1:0]),
		.wr_data (res.val),
		.rd_en   (accept),
		.rd_addr (rs1_in[AW-1:0]),
		.rd_data (rd1_data)
	);

	rv32ie_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_rf_b (
		.clk     (clk),
		.wr_en   (wb),
		.wr_addr (res.rd[AW-1:0]),
		.wr_data (res.val),
		.rd_en   (accept),
		.rd_addr (rs2_in[AW-1:0]),
		.rd_data (rd2_data)
	);

	assign src_a = !ok1_s1 ? 32'd0 : (fwd1_s1 ? fwd_val_s1 : rd1_data);
	assign src_b = !ok2_s1 ? 32'd0 : (fwd2_s1 ? fwd_val_s1 : rd2_data);

	rv32ie_exec #(.REGISTER_COUNT(REGISTER_COUNT)) u_exec (
		.instr (instr_s1),
		.pc    (pc_q),
		.src_a (src_a),
		.src_b (src_b),
		.res   (res)
	);

	assign stall_next = res.jump ? stall_q + rv32ie_pkg::JUMP_STALL : stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			pc_q       <= 32'd0;
			stall_q    <= 32'd0;
			rf_valid_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
				pc_q     <= res.npc;
				stall_q  <= stall_next;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (wb) begin
				rf_valid_q[res.rd[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1   <= instruction;
			ok1_s1     <= reg_ok(rs1_in) && (fwd1 || rf_valid_q[rs1_in[AW-1:0]]);
			ok2_s1     <= reg_ok(rs2_in) && (fwd2 || rf_valid_q[rs2_in[AW-1:0]]);
			fwd1_s1    <= fwd1;
			fwd2_s1    <= fwd2;
			fwd_val_s1 <= res.val;
		end
		if (s1_adv) begin
			write_enable   <= res.wr;
			write_register <= res.rd;
			write_value    <= res.val;
			next_pc        <= res.npc;
			status         <= res.status;
			stall_total    <= stall_next;
		end
	end

	assign out_valid = valid_s2;

endmodule
`default_nettype wire

// ===== rtl/rv32ie_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32ie_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rv32ie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rv32ie_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32ie_exec
// Decode and execute of one instruction: ALU, branch resolve, jumps,
// upper immediates and environment calls.
// ----------------------------------------------------------------------------
module rv32ie_exec #(
	parameter int REGISTER_COUNT = rv32ie_pkg::REGISTER_COUNT
) (
	input  wire logic [31:0]              instr,
	input  wire logic [31:0]              pc,
	input  wire logic [31:0]              src_a,
	input  wire logic [31:0]              src_b,
	output rv32ie_pkg::exec_result_t      res
);

	function automatic logic [31:0] alu(input logic [2:0] f3, input logic [31:0] a,
			input logic [31:0] b, input logic alt_sub, input logic alt_sra);
		logic [4:0]  sh;
		logic [31:0] r;
		sh = b[4:0] & rv32ie_pkg::SHAMT_MASK;
		case (f3)
			rv32ie_pkg::F3_ADD:  r = alt_sub ? a - b : a + b;
			rv32ie_pkg::F3_SLL:  r = a << sh;
			rv32ie_pkg::F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
			rv32ie_pkg::F3_SLTU: r = {31'd0, a < b};
			rv32ie_pkg::F3_XOR:  r = a ^ b;
			rv32ie_pkg::F3_SRL:  r = alt_sra ? 32'($signed(a) >>> sh) : a >> sh;
			rv32ie_pkg::F3_OR:   r = a | b;
			default:             r = a & b;
		endcase
		return r;
	endfunction

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [31:0] pc_plus4;
	logic [31:0] jalr_sum;
	logic        take;
	logic        wr;
	logic [31:0] val;
	logic [31:0] npc;
	logic [1:0]  status;
	logic        jump;
	logic        rd_ok;

	assign opc      = instr[6:0];
	assign rd       = instr[11:7];
	assign f3       = instr[14:12];
	assign f7       = instr[31:25];
	assign imm_i    = {{20{instr[31]}}, instr[31:20]};
	assign imm_b    = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_j    = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
	assign imm_u    = {instr[31:12], 12'd0};
	assign pc_plus4 = pc + rv32ie_pkg::PC_STEP;
	assign jalr_sum = src_a + imm_i;
	assign rd_ok    = (rd != 5'd0) && ({1'b0, rd} < 6'(REGISTER_COUNT));

	always_comb begin
		wr     = 1'b0;
		val    = 32'd0;
		npc    = pc_plus4;
		status = rv32ie_pkg::STATUS_OK;
		jump   = 1'b0;
		take   = 1'b0;
		case (opc)
			rv32ie_pkg::OPC_ARITH_I: begin
				val = alu(f3, src_a, imm_i, 1'b0, f7 != 7'd0);
				wr  = 1'b1;
			end
			rv32ie_pkg::OPC_ARITH_R: begin
				val = alu(f3, src_a, src_b, f7 != 7'd0, f7 != 7'd0);
				wr  = 1'b1;
			end
			rv32ie_pkg::OPC_BRANCH: begin
				case (f3)
					rv32ie_pkg::F3_BEQ:  take = src_a == src_b;
					rv32ie_pkg::F3_BNE:  take = src_a != src_b;
					rv32ie_pkg::F3_BLT:  take = $signed(src_a) < $signed(src_b);
					rv32ie_pkg::F3_BGE:  take = !($signed(src_a) < $signed(src_b));
					rv32ie_pkg::F3_BLTU: take = src_a < src_b;
					rv32ie_pkg::F3_BGEU: take = src_a >= src_b;
					default:             status = rv32ie_pkg::STATUS_ILLEGAL;
				endcase
				if (take) begin
					npc = pc + imm_b;
				end
			end
			rv32ie_pkg::OPC_JALR: begin
				val  = pc_plus4;
				wr   = 1'b1;
				npc  = {jalr_sum[31:1], 1'b0};
				jump = 1'b1;
			end
			rv32ie_pkg::OPC_JAL: begin
				val  = pc_plus4;
				wr   = 1'b1;
				npc  = pc + imm_j;
				jump = 1'b1;
			end
			rv32ie_pkg::OPC_LUI: begin
				val = imm_u;
				wr  = 1'b1;
			end
			rv32ie_pkg::OPC_AUIPC: begin
				val = pc + imm_u;
				wr  = 1'b1;
			end
			rv32ie_pkg::OPC_ENV: begin
				if (f3 != 3'd0) begin
					status = rv32ie_pkg::STATUS_ILLEGAL;
				end else if (instr[31:20] == rv32ie_pkg::ENV_EXIT) begin
					status = rv32ie_pkg::STATUS_EXIT;
					npc    = pc;
				end else if (instr[31:20] == rv32ie_pkg::ENV_HALT) begin
					status = rv32ie_pkg::STATUS_HALT;
				end
			end
			default: begin
				status = rv32ie_pkg::STATUS_ILLEGAL;
			end
		endcase
		if (status == rv32ie_pkg::STATUS_ILLEGAL) begin
			npc = pc;
			wr  = 1'b0;
		end
		wr = wr && rd_ok;
	end

	assign res.wr     = wr;
	assign res.rd     = wr ? rd : 5'd0;
	assign res.val    = wr ? val : 32'd0;
	assign res.npc    = npc;
	assign res.status = status;
	assign res.jump   = jump;

endmodule
`default_nettype wire

// ===== rtl/rv32ie_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32ie_checker
// Port-level checks of the RV32 integer execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module rv32ie_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        write_enable,
	input wire logic [4:0]  write_register,
	input wire logic [31:0] write_value,
	input wire logic [1:0]  status,
	input wire logic [31:0] stall_total
);

	logic out_take;

	assign out_take = out_valid && !out_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> write_register != 5'd0 &&
			status != rv32ie_pkg::STATUS_ILLEGAL)
		else $error("register write to zero or on illegal instruction");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> write_register == 5'd0 && write_value == 32'd0)
		else $error("idle write fields not zero");

	a_stall_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_take) && out_valid && $past(arst_n) |->
			stall_total == $past(stall_total) ||
			stall_total == $past(stall_total) + rv32ie_pkg::JUMP_STALL)
		else $error("stall count moved by more than one jump");

endmodule

bind rv32_integer_execute_unit rv32ie_checker u_rv32ie_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.write_enable   (write_enable),
	.write_register (write_register),
	.write_value    (write_value),
	.status         (status),
	.stall_total    (stall_total)
);
`default_nettype wire
